// ===== sv/sam_pkg.sv =====
package sam_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int ADDR_BITS      = 32;
  localparam int DATA_W         = 32;
  localparam int CNT_OUT_W      = 13;
  localparam int CFG_IDX_W      = 1;

  localparam logic [DATA_W-1:0] POOL_BYTES_RST = 32'd16777216;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = 1'b1;

  localparam logic [2:0] FN_ALLOC       = 3'd0;
  localparam logic [2:0] FN_ALLOC_MOV   = 3'd1;
  localparam logic [2:0] FN_FREE_TOP    = 3'd2;
  localparam logic [2:0] FN_FREE_MOV    = 3'd3;
  localparam logic [2:0] FN_REALLOC_TOP = 3'd4;
  localparam logic [2:0] FN_REALLOC_MOV = 3'd5;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TABLE_FULL,
    ST_NO_MEMORY,
    ST_TABLE_EMPTY,
    ST_NOT_TOP,
    ST_NOT_FOUND,
    ST_FIXED_BEHIND
  } status_t;

  typedef struct packed {
    logic [2:0]              func;
    logic [DATA_W-1:0]       request_bytes;
    logic [ADDR_BITS-1:0]    target_address;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic [ADDR_BITS-1:0]    block_address;
    logic [DATA_W-1:0]       granted_bytes;
    logic [ADDR_BITS-1:0]    move_source;
    logic [DATA_W-1:0]       move_length;
    logic signed [DATA_W:0]  move_delta;
    logic [CNT_OUT_W-1:0]    first_moved_index;
    logic [DATA_W-1:0]       free_bytes_now;
    logic [DATA_W-1:0]       high_mark;
    logic [CNT_OUT_W-1:0]    block_count;
  } rsp_t;

  typedef struct packed {
    logic                    movable;
    logic [DATA_W-1:0]       size;
    logic [ADDR_BITS-1:0]    addr;
  } ent_t;

  // round up to the 8-byte grain at 33 bits, minimum one grain
  function automatic logic [DATA_W:0] round_size(input logic [DATA_W-1:0] req);
    logic [DATA_W:0] sum;
    logic [DATA_W:0] r;
    sum = {1'b0, req} + (DATA_W+1)'(7);
    r   = sum & ~((DATA_W+1)'(7));
    return (r < (DATA_W+1)'(8)) ? (DATA_W+1)'(8) : r;
  endfunction

endpackage

// ===== sv/sam_if.sv =====
interface sam_req_if;
  import sam_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface sam_rsp_if;
  import sam_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/stack_arena_allocator_movable_core.sv =====
// sequence: alloc goes from idle straight to done, free/realloc of the top block via the
//   top state, movable free/realloc via search, scan of the entries above it, decide and move
// throughput: one request at a time; the single read port of the entry table
//   sets the rate at one table entry per cycle during search, scan and move
// reset: counters and pool registers take their reset values synchronously; the
//   entry table is not cleared, only entries below the block count are read
module stack_arena_allocator_movable_core #(
  parameter int MAX_BLOCKS = sam_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sam_req_if.sink                        in_ch,
  sam_rsp_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sam_pkg::DATA_W-1:0]     cfg_wdata
);
  import sam_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE, S_TOP, S_FIND, S_SCAN, S_DECIDE, S_MOVE, S_DONE
  } state_t;

  // entry table
  ent_t mem [MAX_BLOCKS];
  ent_t rd_q;
  logic rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  ent_t wr_data;

  state_t state_r, state_nxt;
  logic [2:0] func_r, func_nxt;
  logic [DATA_W:0] n_r, n_nxt;
  logic [ADDR_BITS-1:0] target_r, target_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;
  logic [DATA_W-1:0] pool_r, pool_nxt;
  logic [DATA_W-1:0] free_r, free_nxt, alloc_r, alloc_nxt, peak_r, peak_nxt;
  logic [CNT_W-1:0] used_r, used_nxt, k_r, k_nxt, nr_r, nr_nxt;
  logic [DATA_W-1:0] sz_r, sz_nxt, sum_r, sum_nxt;
  logic [ADDR_BITS-1:0] naddr_r, naddr_nxt, msrc_r, msrc_nxt;
  logic nmov_r, nmov_nxt;
  status_t res_status_r, res_status_nxt;
  logic [ADDR_BITS-1:0] res_addr_r, res_addr_nxt;
  logic [DATA_W-1:0] res_granted_r, res_granted_nxt;
  logic res_moved_r, res_moved_nxt;
  logic [DATA_W:0] res_mdelta_r, res_mdelta_nxt;
  logic [CNT_W-1:0] res_first_r, res_first_nxt;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_data_r, out_data_nxt;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    logic [DATA_W:0] nreq;
    logic [DATA_W:0] room;
    logic [DATA_W-1:0] new_alloc;
    logic [ADDR_BITS-1:0] top_addr;
    logic [CNT_W-1:0] top_idx;
    logic [CNT_W-1:0] nxt_i;
    ent_t e;

    nreq      = round_size(in_ch.data.request_bytes);
    e         = rd_q;
    room      = {1'b0, free_r} + {1'b0, sz_r};
    new_alloc = alloc_r;
    top_addr  = base_r + alloc_r;
    top_idx   = used_r - 1'b1;
    nxt_i     = k_r + 1'b1;

    state_nxt = state_r;
    func_nxt = func_r; n_nxt = n_r; target_nxt = target_r;
    base_nxt = base_r; pool_nxt = pool_r;
    free_nxt = free_r; alloc_nxt = alloc_r; peak_nxt = peak_r; used_nxt = used_r;
    k_nxt = k_r; nr_nxt = nr_r; sz_nxt = sz_r; sum_nxt = sum_r;
    naddr_nxt = naddr_r; msrc_nxt = msrc_r; nmov_nxt = nmov_r;
    res_status_nxt = res_status_r; res_addr_nxt = res_addr_r;
    res_granted_nxt = res_granted_r; res_moved_nxt = res_moved_r;
    res_mdelta_nxt = res_mdelta_r; res_first_nxt = res_first_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    rd_en = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = '0; wr_data = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_BASE: base_nxt = cfg_wdata;
        CFG_POOL_BYTES: begin
          pool_nxt = cfg_wdata;
          free_nxt = (cfg_wdata >= alloc_r) ? cfg_wdata - alloc_r : '0;
        end
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt        = in_ch.data.func;
          n_nxt           = nreq;
          target_nxt      = in_ch.data.target_address;
          res_status_nxt  = ST_OK;
          res_addr_nxt    = '0;
          res_granted_nxt = '0;
          res_moved_nxt   = 1'b0;
          state_nxt       = S_DONE;
          unique case (in_ch.data.func) inside
            FN_ALLOC, FN_ALLOC_MOV: begin
              if (used_r >= CNT_MAX) res_status_nxt = ST_TABLE_FULL;
              else if (nreq > {1'b0, free_r}) res_status_nxt = ST_NO_MEMORY;
              else begin
                wr_en           = 1'b1;
                wr_addr         = used_r[IDX_W-1:0];
                wr_data.movable = (in_ch.data.func == FN_ALLOC_MOV);
                wr_data.size    = nreq[DATA_W-1:0];
                wr_data.addr    = top_addr;
                used_nxt        = used_r + 1'b1;
                free_nxt        = free_r - nreq[DATA_W-1:0];
                new_alloc       = alloc_r + nreq[DATA_W-1:0];
                alloc_nxt       = new_alloc;
                peak_nxt        = (new_alloc > peak_r) ? new_alloc : peak_r;
                res_addr_nxt    = top_addr;
                res_granted_nxt = nreq[DATA_W-1:0];
              end
            end
            FN_FREE_TOP, FN_REALLOC_TOP: begin
              if (used_r == '0) res_status_nxt = ST_TABLE_EMPTY;
              else begin
                rd_en     = 1'b1;
                rd_addr   = top_idx[IDX_W-1:0];
                state_nxt = S_TOP;
              end
            end
            FN_FREE_MOV, FN_REALLOC_MOV: begin
              if (used_r == '0) res_status_nxt = ST_TABLE_EMPTY;
              else begin
                rd_en     = 1'b1;
                rd_addr   = top_idx[IDX_W-1:0];
                k_nxt     = top_idx;
                state_nxt = S_FIND;
              end
            end
            default: ;
          endcase
        end
      end

      S_TOP: begin
        state_nxt = S_DONE;
        if (e.addr != target_r) res_status_nxt = ST_NOT_TOP;
        else if (func_r == FN_FREE_TOP) begin
          used_nxt     = top_idx;
          alloc_nxt    = alloc_r - e.size;
          free_nxt     = free_r + e.size;
          res_addr_nxt = target_r;
        end else if (n_r > ({1'b0, free_r} + {1'b0, e.size})) begin
          res_status_nxt = ST_NO_MEMORY;
        end else begin
          top_addr        = base_r + (alloc_r - e.size);
          wr_en           = 1'b1;
          wr_addr         = top_idx[IDX_W-1:0];
          wr_data.movable = e.movable;
          wr_data.size    = n_r[DATA_W-1:0];
          wr_data.addr    = top_addr;
          new_alloc       = alloc_r - e.size + n_r[DATA_W-1:0];
          alloc_nxt       = new_alloc;
          free_nxt        = free_r + e.size - n_r[DATA_W-1:0];
          peak_nxt        = (new_alloc > peak_r) ? new_alloc : peak_r;
          res_addr_nxt    = top_addr;
          res_granted_nxt = n_r[DATA_W-1:0];
        end
      end

      // search from the top down, one entry per cycle
      S_FIND: begin
        if (e.addr == target_r) begin
          nr_nxt    = k_r;
          sz_nxt    = e.size;
          naddr_nxt = e.addr;
          nmov_nxt  = e.movable;
          sum_nxt   = '0;
          msrc_nxt  = '0;
          k_nxt     = nxt_i;
          if (nxt_i < used_r) begin
            rd_en     = 1'b1;
            rd_addr   = nxt_i[IDX_W-1:0];
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DECIDE;
          end
        end else if (k_r == '0) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          k_nxt   = k_r - 1'b1;
          rd_en   = 1'b1;
          rd_addr = top_idx[IDX_W-1:0] & '0 | (k_r[IDX_W-1:0] - 1'b1);
        end
      end

      // entries above the target: all must be movable, sum their sizes
      S_SCAN: begin
        if (!e.movable) begin
          res_status_nxt = ST_FIXED_BEHIND;
          state_nxt      = S_DONE;
        end else begin
          sum_nxt = sum_r + e.size;
          if (k_r == nr_r + 1'b1) msrc_nxt = e.addr;
          k_nxt = nxt_i;
          if (nxt_i < used_r) begin
            rd_en   = 1'b1;
            rd_addr = nxt_i[IDX_W-1:0];
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        nxt_i     = nr_r + 1'b1;
        state_nxt = S_DONE;
        if (func_r == FN_FREE_MOV) begin
          alloc_nxt    = alloc_r - sz_r;
          free_nxt     = free_r + sz_r;
          res_addr_nxt = target_r;
          if (sum_r != '0) begin
            res_moved_nxt  = 1'b1;
            res_mdelta_nxt = '0 - {1'b0, sz_r};
            res_first_nxt  = nr_r;
            k_nxt          = nxt_i;
            rd_en          = 1'b1;
            rd_addr        = nxt_i[IDX_W-1:0];
            state_nxt      = S_MOVE;
          end else begin
            used_nxt = used_r - 1'b1;
          end
        end else if (n_r > room) begin
          res_status_nxt = ST_NO_MEMORY;
        end else begin
          wr_en           = 1'b1;
          wr_addr         = nr_r[IDX_W-1:0];
          wr_data.movable = nmov_r;
          wr_data.size    = n_r[DATA_W-1:0];
          wr_data.addr    = naddr_r;
          free_nxt        = free_r + sz_r - n_r[DATA_W-1:0];
          new_alloc       = alloc_r - sz_r + n_r[DATA_W-1:0];
          alloc_nxt       = new_alloc;
          peak_nxt        = (new_alloc > peak_r) ? new_alloc : peak_r;
          res_addr_nxt    = naddr_r;
          res_granted_nxt = n_r[DATA_W-1:0];
          if (sum_r != '0 && n_r[DATA_W-1:0] != sz_r) begin
            res_moved_nxt  = 1'b1;
            res_mdelta_nxt = n_r - {1'b0, sz_r};
            res_first_nxt  = nxt_i;
            k_nxt          = nxt_i;
            rd_en          = 1'b1;
            rd_addr        = nxt_i[IDX_W-1:0];
            state_nxt      = S_MOVE;
          end
        end
      end

      // shift or compact later entries; read ahead one entry while writing back
      S_MOVE: begin
        wr_en           = 1'b1;
        wr_addr         = (func_r == FN_FREE_MOV) ? k_r[IDX_W-1:0] - 1'b1 : k_r[IDX_W-1:0];
        wr_data.movable = e.movable;
        wr_data.size    = e.size;
        wr_data.addr    = e.addr + res_mdelta_r[ADDR_BITS-1:0];
        k_nxt           = nxt_i;
        if (nxt_i < used_r) begin
          rd_en   = 1'b1;
          rd_addr = nxt_i[IDX_W-1:0];
        end else begin
          if (func_r == FN_FREE_MOV) used_nxt = used_r - 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.status            = res_status_r;
          out_data_nxt.block_address     = res_addr_r;
          out_data_nxt.granted_bytes     = res_granted_r;
          out_data_nxt.move_source       = res_moved_r ? msrc_r : '0;
          out_data_nxt.move_length       = res_moved_r ? sum_r : '0;
          out_data_nxt.move_delta        = res_moved_r ? res_mdelta_r : '0;
          out_data_nxt.first_moved_index = res_moved_r ? CNT_OUT_W'(res_first_r)
                                                       : CNT_OUT_W'(used_r);
          out_data_nxt.free_bytes_now    = free_r;
          out_data_nxt.high_mark         = peak_r;
          out_data_nxt.block_count       = CNT_OUT_W'(used_r);
          state_nxt                      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      pool_r      <= POOL_BYTES_RST;
      free_r      <= POOL_BYTES_RST;
      alloc_r     <= '0;
      peak_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      pool_r      <= pool_nxt;
      free_r      <= free_nxt;
      alloc_r     <= alloc_nxt;
      peak_r      <= peak_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r        <= func_nxt;
    n_r           <= n_nxt;
    target_r      <= target_nxt;
    k_r           <= k_nxt;
    nr_r          <= nr_nxt;
    sz_r          <= sz_nxt;
    sum_r         <= sum_nxt;
    naddr_r       <= naddr_nxt;
    msrc_r        <= msrc_nxt;
    nmov_r        <= nmov_nxt;
    res_status_r  <= res_status_nxt;
    res_addr_r    <= res_addr_nxt;
    res_granted_r <= res_granted_nxt;
    res_moved_r   <= res_moved_nxt;
    res_mdelta_r  <= res_mdelta_nxt;
    res_first_r   <= res_first_nxt;
    out_data_r    <= out_data_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_MAX) else $error("block count beyond table depth");

  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= alloc_r) else $error("high mark below allocated total");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en && rd_addr == wr_addr)) else $error("table read and write hit same entry");

  a_move_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> (wr_en && $past(rd_en))) else $error("move step without read data");

endmodule

// ===== tb/stack_arena_allocator_movable_core_test.sv =====
module stack_arena_allocator_movable_core_test;
  import sam_pkg::*;

  localparam int TABLE_DEPTH = MAX_BLOCKS_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_POOL_BASE;
  logic [DATA_W-1:0] cfg_wdata = '0;

  sam_req_if req_ch();
  sam_rsp_if rsp_ch();

  stack_arena_allocator_movable_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(req_ch),
    .out_ch(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // shadow of the allocator table and counters
  logic [ADDR_BITS-1:0] blk_addr [TABLE_DEPTH];
  logic [DATA_W-1:0] blk_size [TABLE_DEPTH];
  bit blk_mov [TABLE_DEPTH];
  int blk_count;
  logic [DATA_W-1:0] free_left, alloc_sum, peak_sum, base_reg, bytes_reg;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  bit took;
  int idle_in_pct, stall_out_pct;
  int errors, n_accepted, n_results, n_moves;
  bit [7:0] status_seen;

  function automatic void push_block(longint unsigned n, bit mov);
    blk_addr[blk_count] = base_reg + alloc_sum;
    blk_size[blk_count] = n[DATA_W-1:0];
    blk_mov[blk_count] = mov;
    blk_count++;
    free_left -= n[DATA_W-1:0];
    alloc_sum += n[DATA_W-1:0];
    if (alloc_sum > peak_sum) peak_sum = alloc_sum;
  endfunction

  function automatic rsp_t step_allocator(req_t q);
    rsp_t o;
    longint unsigned n, sz, mlen;
    int nr, i;
    bit moved, hit, all_mov, mov;
    o = '0;
    o.status = ST_OK;
    n = ({32'b0, q.request_bytes} + 64'd7) & ~64'd7;
    if (n < 8) n = 8;
    moved = 0;
    hit = 0;
    nr = 0;
    if (q.func == FN_FREE_MOV || q.func == FN_REALLOC_MOV) begin
      for (i = blk_count - 1; i >= 0; i--)
        if (!hit && blk_addr[i] == q.target_address) begin
          nr = i;
          hit = 1;
        end
    end
    all_mov = 1;
    mlen = 0;
    if (hit) begin
      for (i = nr + 1; i < blk_count; i++) begin
        if (!blk_mov[i]) all_mov = 0;
        mlen += blk_size[i];
      end
    end
    case (q.func)
      FN_ALLOC, FN_ALLOC_MOV: begin
        if (blk_count >= TABLE_DEPTH) o.status = ST_TABLE_FULL;
        else if (n > free_left) o.status = ST_NO_MEMORY;
        else begin
          push_block(n, q.func == FN_ALLOC_MOV);
          o.block_address = blk_addr[blk_count-1];
          o.granted_bytes = n[DATA_W-1:0];
        end
      end
      FN_FREE_TOP: begin
        if (blk_count == 0) o.status = ST_TABLE_EMPTY;
        else if (blk_addr[blk_count-1] != q.target_address) o.status = ST_NOT_TOP;
        else begin
          blk_count--;
          o.block_address = q.target_address;
          alloc_sum -= blk_size[blk_count];
          free_left += blk_size[blk_count];
        end
      end
      FN_FREE_MOV: begin
        if (blk_count == 0) o.status = ST_TABLE_EMPTY;
        else if (!hit) o.status = ST_NOT_FOUND;
        else if (!all_mov) o.status = ST_FIXED_BEHIND;
        else begin
          sz = blk_size[nr];
          if (mlen != 0) begin
            moved = 1;
            o.move_source = blk_addr[nr+1];
            o.move_length = mlen[DATA_W-1:0];
            o.move_delta = 33'(64'd0 - sz);
            o.first_moved_index = CNT_OUT_W'(nr);
          end
          for (i = nr + 1; i < blk_count; i++) begin
            blk_addr[i-1] = blk_addr[i] - sz[DATA_W-1:0];
            blk_size[i-1] = blk_size[i];
            blk_mov[i-1] = blk_mov[i];
          end
          blk_count--;
          o.block_address = q.target_address;
          alloc_sum -= sz[DATA_W-1:0];
          free_left += sz[DATA_W-1:0];
        end
      end
      FN_REALLOC_TOP: begin
        if (blk_count == 0) o.status = ST_TABLE_EMPTY;
        else if (blk_addr[blk_count-1] != q.target_address) o.status = ST_NOT_TOP;
        else begin
          sz = blk_size[blk_count-1];
          if (n > {32'b0, free_left} + sz) o.status = ST_NO_MEMORY;
          else begin
            mov = blk_mov[blk_count-1];
            blk_count--;
            alloc_sum -= sz[DATA_W-1:0];
            free_left += sz[DATA_W-1:0];
            push_block(n, mov);
            o.block_address = blk_addr[blk_count-1];
            o.granted_bytes = n[DATA_W-1:0];
          end
        end
      end
      FN_REALLOC_MOV: begin
        if (blk_count == 0) o.status = ST_TABLE_EMPTY;
        else if (!hit) o.status = ST_NOT_FOUND;
        else if (!all_mov) o.status = ST_FIXED_BEHIND;
        else if (n > {32'b0, free_left} + blk_size[nr]) o.status = ST_NO_MEMORY;
        else begin
          sz = blk_size[nr];
          if (mlen != 0 && n != sz) begin
            moved = 1;
            o.move_source = blk_addr[nr+1];
            o.move_length = mlen[DATA_W-1:0];
            o.move_delta = 33'(n - sz);
            o.first_moved_index = CNT_OUT_W'(nr + 1);
            for (i = nr + 1; i < blk_count; i++)
              blk_addr[i] = blk_addr[i] + 32'(n - sz);
          end
          free_left = free_left + sz[DATA_W-1:0] - n[DATA_W-1:0];
          alloc_sum = alloc_sum - sz[DATA_W-1:0] + n[DATA_W-1:0];
          blk_size[nr] = n[DATA_W-1:0];
          if (alloc_sum > peak_sum) peak_sum = alloc_sum;
          o.block_address = blk_addr[nr];
          o.granted_bytes = n[DATA_W-1:0];
        end
      end
      default: ;
    endcase
    if (!moved) o.first_moved_index = CNT_OUT_W'(blk_count);
    else n_moves++;
    o.free_bytes_now = free_left;
    o.high_mark = peak_sum;
    o.block_count = CNT_OUT_W'(blk_count);
    return o;
  endfunction

  // driver: new transfer offered at the falling edge
  always @(negedge clk) begin
    if (!req_ch.valid || took) begin
      if (pending_reqs.size() != 0 && $urandom_range(1, 100) > idle_in_pct) begin
        req_ch.data <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    rsp_ch.ready <= ($urandom_range(1, 100) > stall_out_pct);
  end

  // monitor
  always @(posedge clk) begin
    rsp_t want;
    took <= rst_n && req_ch.valid && req_ch.ready;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        n_accepted++;
        expected_rsps.push_back(step_allocator(req_ch.data));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_results++;
        if (expected_rsps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", rsp_ch.data);
        end else begin
          want = expected_rsps.pop_front();
          status_seen[want.status] = 1'b1;
          if (rsp_ch.data !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch on result %0d\n  expected %p\n  actual   %p",
                       n_results, want, rsp_ch.data);
          end
        end
      end
    end
  end

  task automatic issue(logic [2:0] fn, logic [31:0] nbytes, logic [31:0] tgt);
    req_t q;
    q.func = fn;
    q.request_bytes = nbytes;
    q.target_address = tgt;
    pending_reqs.push_back(q);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    drain();
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POOL_BASE) base_reg = val;
    else begin
      bytes_reg = val;
      free_left = (bytes_reg >= alloc_sum) ? bytes_reg - alloc_sum : '0;
    end
  endtask

  task automatic random_item();
    int r, k;
    logic [31:0] nbytes, tgt;
    logic [2:0] fn;
    r = $urandom_range(0, 99);
    k = (blk_count == 0) ? 0 :
        blk_count - 1 - $urandom_range(0, (blk_count - 1 < 6) ? blk_count - 1 : 6);
    nbytes = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200);
    tgt = (blk_count == 0 || $urandom_range(0, 9) == 0) ? $urandom : blk_addr[k];
    if (r < 8) begin
      fn = 3'($urandom_range(0, 7));
      nbytes = $urandom;
      tgt = $urandom;
    end else if (r < 40 || blk_count < 2) begin
      fn = ($urandom_range(0, 9) < 7) ? FN_ALLOC_MOV : FN_ALLOC;
      if (blk_count > 40) begin
        fn = FN_FREE_TOP;
        tgt = blk_addr[blk_count-1];
      end
    end else if (r < 55) begin
      fn = FN_FREE_TOP;
      tgt = blk_addr[blk_count-1];
    end else if (r < 70) fn = FN_FREE_MOV;
    else if (r < 82) begin
      fn = FN_REALLOC_TOP;
      tgt = blk_addr[blk_count-1];
    end else fn = FN_REALLOC_MOV;
    issue(fn, nbytes, tgt);
  endtask

  initial begin
    int ph, j, b, nb;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    idle_in_pct = 0;
    stall_out_pct = 0;
    errors = 0;
    blk_count = 0;
    base_reg = '0;
    bytes_reg = POOL_BYTES_RST;
    free_left = POOL_BYTES_RST;
    alloc_sum = '0;
    peak_sum = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, unused codes, moves, fixed blocks, huge sizes
    issue(FN_FREE_TOP, 0, 0);
    issue(FN_FREE_MOV, 0, 0);
    issue(FN_REALLOC_TOP, 8, 0);
    issue(FN_REALLOC_MOV, 8, 0);
    issue(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(3'd7, 0, 0);
    issue(FN_ALLOC, 0, 0);
    issue(FN_ALLOC_MOV, 9, 0);
    issue(FN_ALLOC_MOV, 100, 0);
    issue(FN_ALLOC_MOV, 16, 0);
    drain();
    issue(FN_REALLOC_MOV, 16, blk_addr[1]);
    drain();
    issue(FN_REALLOC_MOV, 40, blk_addr[1]);
    drain();
    issue(FN_REALLOC_MOV, 0, blk_addr[0]);
    drain();
    issue(FN_FREE_MOV, 0, blk_addr[1]);
    issue(FN_FREE_MOV, 0, 32'h0001_2345);
    issue(FN_ALLOC, 24, 0);
    drain();
    issue(FN_FREE_MOV, 0, blk_addr[1]);
    issue(FN_REALLOC_MOV, 64, blk_addr[1]);
    issue(FN_REALLOC_TOP, 64, blk_addr[blk_count-1]);
    drain();
    issue(FN_REALLOC_TOP, 64, blk_addr[0]);
    issue(FN_FREE_TOP, 0, blk_addr[0]);
    issue(FN_ALLOC, 32'hFFFF_FFFF, 0);
    issue(FN_ALLOC_MOV, 32'hFFFF_FFF9, 0);
    issue(FN_REALLOC_TOP, 32'hFFFF_FFF0, blk_addr[blk_count-1]);
    issue(FN_FREE_MOV, 0, blk_addr[blk_count-1]);
    drain();
    issue(FN_FREE_TOP, 0, blk_addr[blk_count-1]);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_in_pct = 0;  stall_out_pct = 0; end
        1: begin
          idle_in_pct = 77; stall_out_pct = 0;
          write_reg(CFG_POOL_BASE, 32'hFFFF_FC00);
          write_reg(CFG_POOL_BYTES, 32'd2048);
        end
        2: begin
          idle_in_pct = 0; stall_out_pct = 77;
          write_reg(CFG_POOL_BASE, 32'($urandom_range(0, 32'h0FFF_FFFF) << 3));
          write_reg(CFG_POOL_BYTES, 32'hFFFF_FFF8);
        end
        default: begin
          idle_in_pct = 29; stall_out_pct = 29;
          write_reg(CFG_POOL_BASE, 32'd0);
          write_reg(CFG_POOL_BYTES, 32'd0);
          for (j = 0; j < 6; j++) random_item();
          write_reg(CFG_POOL_BYTES, 32'd1000);
        end
      endcase
      b = 0;
      while (b < 137) begin
        nb = $urandom_range(1, 4);
        for (j = 0; j < nb; j++) random_item();
        b += nb;
        if ($urandom_range(0, 19) == 0) drain();
        else while (pending_reqs.size() != 0) @(posedge clk);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (expected_rsps.size() != 0) errors++;
    $display("%0d requests accepted, %0d results checked, %0d reported moves",
             n_accepted, n_results, n_moves);
    $display("status codes seen: %b, %0d failures", status_seen, errors);
    if (errors == 0) begin
      $display("stack_arena_allocator_movable_core_test passed");
    end else begin
      $display("stack_arena_allocator_movable_core_test failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout after %0d results", n_results);
    $display("stack_arena_allocator_movable_core_test failed");
    $finish;
  end

endmodule
